@@ hdl/gss_pkg.sv @@
// ----------------------------------------------------------------------------
// gss_pkg: shared constants and types for the generational sparse set
// Sizes, operation and status codes, and the compare unit's result bundle.
// ----------------------------------------------------------------------------
package gss_pkg;

  // Storage sizes
  localparam int CAPACITY   = 256;
  localparam int VALUE_BITS = 32;
  localparam int GEN_BITS   = 16;
  localparam int SLOT_BITS  = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int OP_BITS    = 3;
  localparam int STAT_BITS  = 3;
  localparam int CMP_BITS   = (GEN_BITS > COUNT_BITS) ? GEN_BITS : COUNT_BITS;

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_ACQUIRE    = 3'd0;
  localparam logic [OP_BITS-1:0] OP_DISCARD    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_GET        = 3'd2;
  localparam logic [OP_BITS-1:0] OP_SET        = 3'd3;
  localparam logic [OP_BITS-1:0] OP_CLEAR      = 3'd4;
  localparam logic [OP_BITS-1:0] OP_READ_INDEX = 3'd5;

  // Status codes
  localparam logic [STAT_BITS-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_BITS-1:0] ST_NULL     = 3'd1;
  localparam logic [STAT_BITS-1:0] ST_RANGE    = 3'd2;
  localparam logic [STAT_BITS-1:0] ST_STALE    = 3'd3;
  localparam logic [STAT_BITS-1:0] ST_NOT_LIVE = 3'd4;
  localparam logic [STAT_BITS-1:0] ST_FULL     = 3'd5;
  localparam logic [STAT_BITS-1:0] ST_INDEX    = 3'd6;

  // Compare unit flags
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

@@ hdl/gss_if.sv @@
// ----------------------------------------------------------------------------
// gss_if: request and result channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface gss_req_if;
  logic                            valid;
  logic                            ready;
  logic [gss_pkg::OP_BITS-1:0]     operation;
  logic [gss_pkg::COUNT_BITS-1:0]  handle_num;
  logic [gss_pkg::GEN_BITS-1:0]    handle_gen;
  logic [gss_pkg::VALUE_BITS-1:0]  value;
  logic [gss_pkg::SLOT_BITS-1:0]   index;

  modport source (output valid, operation, handle_num, handle_gen, value, index,
                  input ready);
  modport sink   (input valid, operation, handle_num, handle_gen, value, index,
                  output ready);
endinterface

interface gss_res_if;
  logic                            valid;
  logic                            ready;
  logic [gss_pkg::STAT_BITS-1:0]   status;
  logic [gss_pkg::COUNT_BITS-1:0]  out_handle_num;
  logic [gss_pkg::GEN_BITS-1:0]    out_handle_gen;
  logic [gss_pkg::VALUE_BITS-1:0]  out_value;
  logic [gss_pkg::COUNT_BITS-1:0]  live_count;

  modport source (output valid, status, out_handle_num, out_handle_gen, out_value,
                  live_count, input ready);
  modport sink   (input valid, status, out_handle_num, out_handle_gen, out_value,
                  live_count, output ready);
endinterface

@@ hdl/gss_ram.sv @@
// ----------------------------------------------------------------------------
// gss_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module gss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/gss_cmp.sv @@
// ----------------------------------------------------------------------------
// gss_cmp: shared compare unit
// Unsigned less-than and equality on one operand pair, reused by each compare step.
// ----------------------------------------------------------------------------
module gss_cmp (
  input  logic [gss_pkg::CMP_BITS-1:0] a,
  input  logic [gss_pkg::CMP_BITS-1:0] b,
  output gss_pkg::cmp_res_t            res
);

  // Compare the selected operands
  always_comb begin
    res.lt = (a < b);
    res.eq = (a == b);
  end

endmodule

@@ hdl/generational_sparse_set_unit.sv @@
// ----------------------------------------------------------------------------
// generational_sparse_set_unit: slot map with generation-checked handles
// Dense value store, dense-to-slot map and slot table with generations,
// driven by a small sequencer around one shared compare unit.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+-------------------------------------------
//  request  | in  | valid/ready | operation, handle_num, handle_gen, value, index
//  result   | out | valid/ready | status, out_handle_num, out_handle_gen,
//           |     |             | out_value, live_count
//
//  One request at a time; request.ready is high only while the sequencer idles.
//  Each step uses the compare unit at most once; the RAM reads are registered.
//  Reset clears the counters, free-list head and result valid; RAMs keep data.
//  A result waiting on result.ready holds the next request in its final step.
// ----------------------------------------------------------------------------
module generational_sparse_set_unit (
  input  logic      clk,
  input  logic      rst,
  gss_req_if.sink   request,
  gss_res_if.source result
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACQ_FULL,
    S_ACQ_FREE,
    S_ACQ_WR,
    S_CHK_NULL,
    S_CHK_RANGE,
    S_CHK_GEN,
    S_CHK_POS,
    S_CHK_OWN,
    S_DIS_LAST,
    S_DIS_MOVE,
    S_DIS_FREE,
    S_IDX_CHK,
    S_IDX_SLOT,
    S_IDX_GEN,
    S_FIN
  } state_t;

  localparam int SB = gss_pkg::SLOT_BITS;
  localparam int CB = gss_pkg::COUNT_BITS;
  localparam int GB = gss_pkg::GEN_BITS;
  localparam int VB = gss_pkg::VALUE_BITS;
  localparam int MB = gss_pkg::CMP_BITS;

  state_t state;

  // Latched request
  logic [gss_pkg::OP_BITS-1:0] op_q;
  logic [CB-1:0]               hid_q;
  logic [GB-1:0]               hgen_q;
  logic [VB-1:0]               val_q;
  logic [SB-1:0]               idx_q;
  logic [SB-1:0]               slot_q;
  logic [CB-1:0]               pos_q;

  // Set bookkeeping
  logic [CB-1:0] free_head;
  logic [CB-1:0] slots_used;
  logic [CB-1:0] entry_count;

  // Pending result
  logic [gss_pkg::STAT_BITS-1:0] res_status;
  logic [CB-1:0]                 res_id;
  logic [GB-1:0]                 res_gen;
  logic [VB-1:0]                 res_val;

  // Output register
  logic                          out_valid;
  logic [gss_pkg::STAT_BITS-1:0] out_status;
  logic [CB-1:0]                 out_id;
  logic [GB-1:0]                 out_gen;
  logic [VB-1:0]                 out_val;
  logic [CB-1:0]                 out_live;

  // RAM ports
  logic          dv_we,  d2s_we,  link_we,  gen_we;
  logic [SB-1:0] dv_wa,  d2s_wa,  link_wa,  gen_wa;
  logic [SB-1:0] dv_ra,  d2s_ra,  link_ra,  gen_ra;
  logic [VB-1:0] dv_wd,  dv_rd;
  logic [SB-1:0] d2s_wd, d2s_rd;
  logic [CB-1:0] link_wd, link_rd;
  logic [GB-1:0] gen_wd, gen_rd;

  // Compare unit
  logic [MB-1:0]      cmp_a;
  logic [MB-1:0]      cmp_b;
  gss_pkg::cmp_res_t  cmp;

  gss_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  gss_ram #(.WIDTH(VB), .DEPTH(gss_pkg::CAPACITY)) u_dense_values (
    .clk (clk), .we (dv_we), .waddr (dv_wa), .wdata (dv_wd),
    .raddr (dv_ra), .rdata (dv_rd)
  );

  gss_ram #(.WIDTH(SB), .DEPTH(gss_pkg::CAPACITY)) u_dense_to_slot (
    .clk (clk), .we (d2s_we), .waddr (d2s_wa), .wdata (d2s_wd),
    .raddr (d2s_ra), .rdata (d2s_rd)
  );

  gss_ram #(.WIDTH(CB), .DEPTH(gss_pkg::CAPACITY)) u_slot_link (
    .clk (clk), .we (link_we), .waddr (link_wa), .wdata (link_wd),
    .raddr (link_ra), .rdata (link_rd)
  );

  gss_ram #(.WIDTH(GB), .DEPTH(gss_pkg::CAPACITY)) u_slot_generation (
    .clk (clk), .we (gen_we), .waddr (gen_wa), .wdata (gen_wd),
    .raddr (gen_ra), .rdata (gen_rd)
  );

  // Handshake and result ports
  assign request.ready         = (state == S_IDLE);
  assign result.valid          = out_valid;
  assign result.status         = out_status;
  assign result.out_handle_num = out_id;
  assign result.out_handle_gen = out_gen;
  assign result.out_value      = out_val;
  assign result.live_count     = out_live;

  // Select compare operands for the current step
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state)
      S_ACQ_FULL: begin
        cmp_a = MB'(entry_count);
        cmp_b = MB'(gss_pkg::CAPACITY);
      end
      S_ACQ_FREE: begin
        cmp_a = MB'(free_head);
        cmp_b = MB'(slots_used);
      end
      S_CHK_NULL: begin
        cmp_a = MB'(hid_q);
        cmp_b = '0;
      end
      S_CHK_RANGE: begin
        cmp_a = MB'(slots_used);
        cmp_b = MB'(hid_q);
      end
      S_CHK_GEN: begin
        cmp_a = MB'(hgen_q);
        cmp_b = MB'(gen_rd);
      end
      S_CHK_POS, S_DIS_LAST: begin
        cmp_a = MB'(pos_q);
        cmp_b = MB'(entry_count);
      end
      S_CHK_OWN: begin
        cmp_a = MB'(d2s_rd);
        cmp_b = MB'(slot_q);
      end
      S_IDX_CHK: begin
        cmp_a = MB'(idx_q);
        cmp_b = MB'(entry_count);
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  // Drive RAM reads and writes for the current step
  always_comb begin
    dv_we   = 1'b0;
    dv_wa   = entry_count[SB-1:0];
    dv_wd   = val_q;
    d2s_we  = 1'b0;
    d2s_wa  = entry_count[SB-1:0];
    d2s_wd  = slots_used[SB-1:0];
    link_we = 1'b0;
    link_wa = slot_q;
    link_wd = entry_count;
    gen_we  = 1'b0;
    gen_wa  = slot_q;
    gen_wd  = '0;
    dv_ra   = pos_q[SB-1:0];
    d2s_ra  = pos_q[SB-1:0];
    link_ra = slot_q;
    gen_ra  = slot_q;
    case (state)
      S_ACQ_FREE: begin
        link_ra = free_head[SB-1:0];
        gen_ra  = free_head[SB-1:0];
        if (!cmp.lt) begin
          // fresh slot at the top of the table
          gen_we  = 1'b1;
          gen_wa  = slots_used[SB-1:0];
          gen_wd  = '0;
          link_we = 1'b1;
          link_wa = slots_used[SB-1:0];
          link_wd = entry_count;
          d2s_we  = 1'b1;
          d2s_wd  = slots_used[SB-1:0];
          dv_we   = 1'b1;
        end
      end
      S_ACQ_WR: begin
        link_we = 1'b1;
        link_wa = free_head[SB-1:0];
        link_wd = entry_count;
        d2s_we  = 1'b1;
        d2s_wd  = free_head[SB-1:0];
        dv_we   = 1'b1;
      end
      S_CHK_RANGE: begin
        link_ra = slot_q;
        gen_ra  = slot_q;
      end
      S_CHK_POS: begin
        dv_ra  = pos_q[SB-1:0];
        d2s_ra = pos_q[SB-1:0];
      end
      S_CHK_OWN: begin
        if (cmp.eq && (op_q == gss_pkg::OP_SET)) begin
          dv_we = 1'b1;
          dv_wa = pos_q[SB-1:0];
          dv_wd = val_q;
        end
      end
      S_DIS_LAST: begin
        dv_ra  = entry_count[SB-1:0];
        d2s_ra = entry_count[SB-1:0];
      end
      S_DIS_MOVE: begin
        // move the last entry into the hole
        d2s_we  = 1'b1;
        d2s_wa  = pos_q[SB-1:0];
        d2s_wd  = d2s_rd;
        dv_we   = 1'b1;
        dv_wa   = pos_q[SB-1:0];
        dv_wd   = dv_rd;
        link_we = 1'b1;
        link_wa = d2s_rd;
        link_wd = pos_q;
      end
      S_DIS_FREE: begin
        link_we = 1'b1;
        link_wa = slot_q;
        link_wd = free_head;
        gen_we  = 1'b1;
        gen_wa  = slot_q;
        gen_wd  = hgen_q + GB'(1);
      end
      S_IDX_CHK: begin
        dv_ra  = idx_q;
        d2s_ra = idx_q;
      end
      S_IDX_SLOT: begin
        gen_ra = d2s_rd;
      end
      default: begin
        dv_we = 1'b0;
      end
    endcase
  end

  // Sequencer, bookkeeping and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      free_head   <= '0;
      slots_used  <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      // drop the taken result unless the final step reloads it
      if (out_valid && result.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (request.valid) begin
            op_q       <= request.operation;
            hid_q      <= request.handle_num;
            hgen_q     <= request.handle_gen;
            val_q      <= request.value;
            idx_q      <= request.index;
            slot_q     <= request.handle_num[SB-1:0] - SB'(1);
            res_status <= gss_pkg::ST_OK;
            res_id     <= '0;
            res_gen    <= '0;
            res_val    <= '0;
            case (request.operation)
              gss_pkg::OP_ACQUIRE:    state <= S_ACQ_FULL;
              gss_pkg::OP_DISCARD:    state <= S_CHK_NULL;
              gss_pkg::OP_GET:        state <= S_CHK_NULL;
              gss_pkg::OP_SET:        state <= S_CHK_NULL;
              gss_pkg::OP_CLEAR: begin
                free_head   <= '0;
                slots_used  <= '0;
                entry_count <= '0;
                state       <= S_FIN;
              end
              gss_pkg::OP_READ_INDEX: state <= S_IDX_CHK;
              default:                state <= S_FIN;
            endcase
          end
        end
        S_ACQ_FULL: begin
          if (cmp.eq) begin
            res_status <= gss_pkg::ST_FULL;
            state      <= S_FIN;
          end else begin
            state <= S_ACQ_FREE;
          end
        end
        S_ACQ_FREE: begin
          if (cmp.lt) begin
            state <= S_ACQ_WR;
          end else begin
            free_head   <= slots_used + CB'(1);
            slots_used  <= slots_used + CB'(1);
            entry_count <= entry_count + CB'(1);
            res_id      <= slots_used + CB'(1);
            res_gen     <= '0;
            state       <= S_FIN;
          end
        end
        S_ACQ_WR: begin
          // pop the free list
          free_head   <= link_rd;
          entry_count <= entry_count + CB'(1);
          res_id      <= free_head + CB'(1);
          res_gen     <= gen_rd;
          state       <= S_FIN;
        end
        S_CHK_NULL: begin
          if (cmp.eq) begin
            res_status <= gss_pkg::ST_NULL;
            state      <= S_FIN;
          end else begin
            state <= S_CHK_RANGE;
          end
        end
        S_CHK_RANGE: begin
          if (cmp.lt) begin
            res_status <= gss_pkg::ST_RANGE;
            state      <= S_FIN;
          end else begin
            state <= S_CHK_GEN;
          end
        end
        S_CHK_GEN: begin
          pos_q <= link_rd;
          if (!cmp.eq) begin
            res_status <= gss_pkg::ST_STALE;
            state      <= S_FIN;
          end else begin
            state <= S_CHK_POS;
          end
        end
        S_CHK_POS: begin
          if (!cmp.lt) begin
            res_status <= gss_pkg::ST_NOT_LIVE;
            state      <= S_FIN;
          end else begin
            state <= S_CHK_OWN;
          end
        end
        S_CHK_OWN: begin
          if (!cmp.eq) begin
            res_status <= gss_pkg::ST_NOT_LIVE;
            state      <= S_FIN;
          end else begin
            case (op_q)
              gss_pkg::OP_GET: begin
                res_val <= dv_rd;
                state   <= S_FIN;
              end
              gss_pkg::OP_DISCARD: begin
                entry_count <= entry_count - CB'(1);
                state       <= S_DIS_LAST;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_DIS_LAST: begin
          if (cmp.lt) begin
            state <= S_DIS_MOVE;
          end else begin
            state <= S_DIS_FREE;
          end
        end
        S_DIS_MOVE: begin
          state <= S_DIS_FREE;
        end
        S_DIS_FREE: begin
          // push the slot on the free list
          free_head <= CB'(slot_q);
          state     <= S_FIN;
        end
        S_IDX_CHK: begin
          if (!cmp.lt) begin
            res_status <= gss_pkg::ST_INDEX;
            state      <= S_FIN;
          end else begin
            state <= S_IDX_SLOT;
          end
        end
        S_IDX_SLOT: begin
          res_id  <= CB'(d2s_rd) + CB'(1);
          res_val <= dv_rd;
          state   <= S_IDX_GEN;
        end
        S_IDX_GEN: begin
          res_gen <= gen_rd;
          state   <= S_FIN;
        end
        S_FIN: begin
          // hand over once the output register is free
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_id     <= res_id;
            out_gen    <= res_gen;
            out_val    <= res_val;
            out_live   <= entry_count;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
